FILE: sv/assert_macros.svh
// Assertion helpers included by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// ante must imply cons at every clock edge outside reset
`define ASRT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// cond must never hold outside reset
`define ASRT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("assertion failed: forbidden condition");
`else
`define ASRT_IMPL(lbl, clk, rstn, ante, cons)
`define ASRT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: sv/wsbg_pkg.sv
package wsbg_pkg;

  localparam int unsigned FFT_SIZE_DEF = 1024;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned DAT_W   = 24;
  localparam int unsigned FC_W    = 16;
  localparam int unsigned PWR_W   = 48;
  localparam int unsigned NUM_W   = 64;
  localparam int unsigned DV_W    = FC_W + 1;
  localparam int unsigned GR_W    = PWR_W + 1;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned RED_W   = 7;
  localparam int unsigned K_W     = 23;
  localparam int unsigned CFG_IDX_W = 1;

  // average quotient fits the power width; gain quotient is Q0.16
  localparam int unsigned QSTEPS = PWR_W;
  localparam int unsigned GSTEPS = GAIN_W;

  localparam logic [RED_W-1:0] RED_MAX = 7'd100;

  // |x*k| / 6553600 = (|x*k| >> 18) / 25
  localparam int unsigned B_W     = 28;
  localparam int unsigned M_W     = 30;
  localparam int unsigned PE_W    = B_W + M_W;
  localparam int unsigned R_SHIFT = 34;
  localparam logic [M_W-1:0] RECIP25 = 30'd687194767;  // floor(2^34 / 25)

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REDUCTION = 1'b0,
    REG_CAPTURE   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                    valid;
    logic                    inr;
    logic [IDX_W-1:0]        idx;
    logic signed [DAT_W-1:0] re;
    logic signed [DAT_W-1:0] im;
  } car_t;

  typedef struct packed {
    logic                    valid;
    logic                    inr;
    logic [IDX_W-1:0]        idx;
    logic signed [DAT_W-1:0] re;
    logic signed [DAT_W-1:0] im;
    logic [PWR_W-1:0]        p;
    logic [DV_W-1:0]         rem;
    logic [DV_W-1:0]         dv;
    logic [PWR_W-1:0]        q;
  } avg_t;

  typedef struct packed {
    logic                    valid;
    logic                    inr;
    logic [IDX_W-1:0]        idx;
    logic signed [DAT_W-1:0] re;
    logic signed [DAT_W-1:0] im;
    logic [GR_W-1:0]         rem;
    logic [GR_W-1:0]         dv;
    logic [GAIN_W-1:0]       q;
  } gain_t;

endpackage

FILE: sv/wsbg_if.sv
interface wsbg_in_if import wsbg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        bin_index;
  logic signed [DAT_W-1:0] bin_real;
  logic signed [DAT_W-1:0] bin_imag;
  logic [FC_W-1:0]         frame_count;

  modport source (output valid, bin_index, bin_real, bin_imag, frame_count, input ready);
  modport sink   (input valid, bin_index, bin_real, bin_imag, frame_count, output ready);
endinterface

interface wsbg_out_if import wsbg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_index;
  logic signed [DAT_W-1:0] out_real;
  logic signed [DAT_W-1:0] out_imag;

  modport source (output valid, out_index, out_real, out_imag, input ready);
  modport sink   (input valid, out_index, out_real, out_imag, output ready);
endinterface

FILE: sv/wsbg_ram.sv
module wsbg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/wsbg_avg_cell.sv
// One restoring step of the noise running-mean divide.
module wsbg_avg_cell import wsbg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  avg_t cin,
  output avg_t cout
);

  logic [DV_W:0] t;
  logic [DV_W:0] diff;
  logic          take;
  avg_t          cell_nxt;
  avg_t          cell_r;

  always_comb begin
    t    = {cin.rem, cin.q[PWR_W-1]};
    diff = t - {1'b0, cin.dv};
    take = (t >= {1'b0, cin.dv});
    cell_nxt     = cin;
    cell_nxt.rem = take ? diff[DV_W-1:0] : t[DV_W-1:0];
    cell_nxt.q   = {cin.q[PWR_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cout = cell_r;

endmodule

FILE: sv/wsbg_gain_cell.sv
// One restoring step of the Q0.16 gain divide (zeros shifted in).
module wsbg_gain_cell import wsbg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  gain_t cin,
  output gain_t cout
);

  logic [GR_W:0] t;
  logic [GR_W:0] diff;
  logic          take;
  gain_t         cell_nxt;
  gain_t         cell_r;

  always_comb begin
    t    = {cin.rem, 1'b0};
    diff = t - {1'b0, cin.dv};
    take = (t >= {1'b0, cin.dv});
    cell_nxt     = cin;
    cell_nxt.rem = take ? diff[GR_W-1:0] : t[GR_W-1:0];
    cell_nxt.q   = {cin.q[GAIN_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cout = cell_r;

endmodule

FILE: sv/wsbg_blend.sv
// y = trunc(x * k / 6553600), three register stages, result combinational
// from the last stage.
module wsbg_blend import wsbg_pkg::*; (
  input  logic                    clk,
  input  logic                    adv,
  input  logic signed [DAT_W-1:0] x,
  input  logic [K_W-1:0]          k,
  output logic signed [DAT_W-1:0] y
);

  logic signed [2*DAT_W-1:0] m_r;
  logic [2*DAT_W-1:0]        am;
  logic [B_W-1:0]            b_r;
  logic                      neg_r;
  logic [PE_W-1:0]           pe;
  logic [DAT_W-1:0]          qe_r;
  logic [B_W-1:0]            b2_r;
  logic                      neg2_r;
  logic [B_W:0]              qe25;
  logic [B_W:0]              rem;
  logic [DAT_W-1:0]          q1;

  assign am = m_r[2*DAT_W-1] ? (2*DAT_W)'(-m_r) : (2*DAT_W)'(m_r);
  assign pe = b_r * RECIP25;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r    <= x * $signed({1'b0, k});
      b_r    <= am[B_W+17:18];
      neg_r  <= m_r[2*DAT_W-1];
      qe_r   <= pe[PE_W-1:R_SHIFT];
      b2_r   <= b_r;
      neg2_r <= neg_r;
    end
  end

  // estimate is exact or one low
  always_comb begin
    qe25 = {{(B_W+1-DAT_W){1'b0}}, qe_r} * (B_W+1)'(25);
    rem  = {1'b0, b2_r} - qe25;
    q1   = (rem >= (B_W+1)'(25)) ? qe_r + 1'b1 : qe_r;
    y    = neg2_r ? $signed(~q1 + 1'b1) : $signed(q1);
  end

endmodule

FILE: sv/wiener_spectral_bin_gain_core.sv
// Wiener spectral gain core: one complex bin per item in, one processed bin
// per item out, in order. After reset all FFT_SIZE/2+1 noise entries (513 at
// the default size) are cleared; no item is taken then. After that the core
// takes one item per clock unless held as below. The path runs through the
// input stage, power and product stages, a 48-cell divider chain for the
// noise running mean, a 16-cell divider chain for the Q0.16 gain and the
// blend multiply / divide-by-constant pipeline. The noise store is a single
// RAM with its read at item entry and its write at the end of the mean
// chain, so while capture is on, a bin whose previous update is in flight
// up to the end of the mean chain holds the input until that update is
// written; bins of one frame spaced wider than that span flow at full rate.
// The whole pipeline stalls only when the output item is held by the sink.
`include "assert_macros.svh"

module wiener_spectral_bin_gain_core import wsbg_pkg::*; #(
  parameter int unsigned FFT_SIZE = FFT_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RED_W-1:0]     cfg_wdata,
  wsbg_in_if.sink              in_ch,
  wsbg_out_if.source           out_ch
);

  localparam int unsigned NBINS = FFT_SIZE / 2 + 1;
  localparam int unsigned AW    = $clog2(NBINS);

  function automatic logic [DAT_W-1:0] mag24(input logic signed [DAT_W-1:0] v);
    return v[DAT_W-1] ? ~v + 1'b1 : v;
  endfunction

  // ---------------- configuration ----------------
  logic [RED_W-1:0] red_r;
  logic             cap_r;
  logic [RED_W-1:0] r_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r <= '0;
      cap_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REDUCTION: red_r <= cfg_wdata;
        REG_CAPTURE:   cap_r <= cfg_wdata[0];
      endcase
    end
  end

  // reduction above 100 % acts as 100 %
  assign r_sat = (red_r > RED_MAX) ? RED_MAX : red_r;

  // ---------------- clearing pass over the noise store ----------------
  logic          clr_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      if (clr_cnt_r == AW'(NBINS - 1)) begin
        clr_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // ---------------- handshake ----------------
  logic adv;
  logic accept;
  logic in_inr;
  logic hit;
  logic hazard;
  logic out_valid_r;

  car_t             sa_r, sb_r, sc_r, sf_r;
  car_t             sg_r [3];
  avg_t             achain [QSTEPS+1];
  gain_t            gchain [GSTEPS+1];

  // pipeline moves whenever the output register is free or being taken
  assign adv    = !out_valid_r || out_ch.ready;
  assign in_inr = (32'(in_ch.bin_index) < NBINS);

  // read-after-write on the noise store: same bin still in flight
  always_comb begin
    hit = (sa_r.valid && sa_r.idx == in_ch.bin_index) ||
          (sb_r.valid && sb_r.idx == in_ch.bin_index) ||
          (sc_r.valid && sc_r.idx == in_ch.bin_index);
    for (int i = 0; i <= QSTEPS; i++) begin
      hit = hit || (achain[i].valid && achain[i].idx == in_ch.bin_index);
    end
  end

  assign hazard      = cap_r && in_inr && hit;
  assign in_ch.ready = adv && !clr_r && !hazard;
  assign accept      = in_ch.valid && in_ch.ready;

  // ---------------- noise store ----------------
  logic             wr_fin;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PWR_W-1:0] ram_wdata;
  logic [PWR_W-1:0] old_pwr;

  assign wr_fin    = achain[QSTEPS].valid && achain[QSTEPS].inr && cap_r;
  assign ram_we    = clr_r || wr_fin;
  assign ram_waddr = clr_r ? clr_cnt_r : AW'(achain[QSTEPS].idx);
  assign ram_wdata = clr_r ? '0 : achain[QSTEPS].q;

  wsbg_ram #(
    .WIDTH (PWR_W),
    .DEPTH (NBINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv),
    .raddr (AW'(in_ch.bin_index)),
    .rdata (old_pwr)
  );

  // ---------------- stage a: input register ----------------
  logic [FC_W-1:0] fc_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r.valid <= 1'b0;
    end else if (adv) begin
      sa_r.valid <= accept;
      sa_r.inr   <= in_inr;
      sa_r.idx   <= in_ch.bin_index;
      sa_r.re    <= in_ch.bin_real;
      sa_r.im    <= in_ch.bin_imag;
      fc_a_r     <= in_ch.frame_count;
    end
  end

  // ---------------- stage b: squares and fc*old partial products ----------------
  // with capture off the mean chain computes old / 1
  logic [FC_W-1:0]         fc_eff;
  logic signed [PWR_W-1:0] sqr, sqi;
  logic [PWR_W-1:0]        sqr_r, sqi_r;
  logic [2*FC_W-1:0]       pp0_r, pp1_r, pp2_r;
  logic [DV_W-1:0]         dv_b_r;

  assign fc_eff = cap_r ? fc_a_r : FC_W'(1);
  assign sqr    = sa_r.re * sa_r.re;
  assign sqi    = sa_r.im * sa_r.im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.valid <= 1'b0;
    end else if (adv) begin
      sb_r   <= sa_r;
      sqr_r  <= PWR_W'(sqr);
      sqi_r  <= PWR_W'(sqi);
      pp0_r  <= fc_eff * old_pwr[15:0];
      pp1_r  <= fc_eff * old_pwr[31:16];
      pp2_r  <= fc_eff * old_pwr[47:32];
      dv_b_r <= cap_r ? ({1'b0, fc_a_r} + 1'b1) : DV_W'(1);
    end
  end

  // ---------------- stage c: power and full product ----------------
  logic [PWR_W-1:0] p_c_r;
  logic [NUM_W-1:0] prod_c_r;
  logic [DV_W-1:0]  dv_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r.valid <= 1'b0;
    end else if (adv) begin
      sc_r     <= sb_r;
      p_c_r    <= sqr_r + sqi_r;
      prod_c_r <= {32'd0, pp0_r} + {16'd0, pp1_r, 16'd0} + {pp2_r, 32'd0};
      dv_c_r   <= dv_b_r;
    end
  end

  // ---------------- stage d: mean numerator, head of the mean chain ----------------
  logic [NUM_W-1:0] num;
  avg_t             d_nxt;
  avg_t             d_r;

  always_comb begin
    num         = prod_c_r + (cap_r ? {16'd0, p_c_r} : NUM_W'(0));
    d_nxt.valid = sc_r.valid;
    d_nxt.inr   = sc_r.inr;
    d_nxt.idx   = sc_r.idx;
    d_nxt.re    = sc_r.re;
    d_nxt.im    = sc_r.im;
    d_nxt.p     = p_c_r;
    d_nxt.rem   = {1'b0, num[NUM_W-1:PWR_W]};
    d_nxt.dv    = dv_c_r;
    d_nxt.q     = num[PWR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign achain[0] = d_r;

  for (genvar i = 0; i < QSTEPS; i++) begin : g_avg
    wsbg_avg_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .cin   (achain[i]),
      .cout  (achain[i+1])
    );
  end

  // ---------------- stage e: gain divisor, head of the gain chain ----------------
  gain_t e_nxt;
  gain_t e_r;

  always_comb begin
    e_nxt.valid = achain[QSTEPS].valid;
    e_nxt.inr   = achain[QSTEPS].inr;
    e_nxt.idx   = achain[QSTEPS].idx;
    e_nxt.re    = achain[QSTEPS].re;
    e_nxt.im    = achain[QSTEPS].im;
    e_nxt.rem   = {1'b0, achain[QSTEPS].p};
    // p + noise + 1: epsilon of one power LSB, never zero
    e_nxt.dv    = {1'b0, achain[QSTEPS].p} + {1'b0, achain[QSTEPS].q} + 1'b1;
    e_nxt.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.valid <= 1'b0;
    end else if (adv) begin
      e_r <= e_nxt;
    end
  end

  assign gchain[0] = e_r;

  for (genvar j = 0; j < GSTEPS; j++) begin : g_gain
    wsbg_gain_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .cin   (gchain[j]),
      .cout  (gchain[j+1])
    );
  end

  // ---------------- stage f: blend weight k = g*R + 65536*(100-R) ----------------
  logic [K_W-1:0] gr;
  logic [K_W-1:0] k_r;

  assign gr = gchain[GSTEPS].q * r_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r.valid <= 1'b0;
    end else if (adv) begin
      sf_r.valid <= gchain[GSTEPS].valid;
      sf_r.inr   <= gchain[GSTEPS].inr;
      sf_r.idx   <= gchain[GSTEPS].idx;
      sf_r.re    <= gchain[GSTEPS].re;
      sf_r.im    <= gchain[GSTEPS].im;
      k_r        <= gr + {RED_MAX - r_sat, 16'd0};
    end
  end

  // ---------------- blend pipelines ----------------
  logic signed [DAT_W-1:0] y_re, y_im;
  logic signed [DAT_W-1:0] res_re, res_im;

  wsbg_blend u_bl_re (.clk(clk), .adv(adv), .x(sf_r.re), .k(k_r), .y(y_re));
  wsbg_blend u_bl_im (.clk(clk), .adv(adv), .x(sf_r.im), .k(k_r), .y(y_im));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_r[0].valid <= 1'b0;
      sg_r[1].valid <= 1'b0;
      sg_r[2].valid <= 1'b0;
    end else if (adv) begin
      sg_r[0] <= sf_r;
      sg_r[1] <= sg_r[0];
      sg_r[2] <= sg_r[1];
    end
  end

  // bins past FFT_SIZE/2 pass through untouched
  assign res_re = sg_r[2].inr ? y_re : sg_r[2].re;
  assign res_im = sg_r[2].inr ? y_im : sg_r[2].im;

  // ---------------- output register ----------------
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [DAT_W-1:0] out_re_r, out_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sg_r[2].valid;
      out_idx_r   <= sg_r[2].idx;
      out_re_r    <= res_re;
      out_im_r    <= res_im;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_index = out_idx_r;
  assign out_ch.out_real  = out_re_r;
  assign out_ch.out_imag  = out_im_r;

  // ---------------- checks ----------------
  // a new item never reads the entry that is being written back this cycle
  `ASRT_NEVER(a_rw_collide, clk, rst_n, wr_fin && accept && (in_ch.bin_index == achain[QSTEPS].idx))
  // mean quotient always fits the 48-bit store
  `ASRT_IMPL(a_avg_fits, clk, rst_n, achain[0].valid && achain[0].inr, achain[0].rem < achain[0].dv)
  // blend never grows a bin
  `ASRT_IMPL(a_out_mag, clk, rst_n, adv && sg_r[2].valid, (mag24(res_re) <= mag24(sg_r[2].re)) && (mag24(res_im) <= mag24(sg_r[2].im)))

endmodule

FILE: verif/wsbg_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces come with the RTL (wsbg_in_if, wsbg_out_if).
// This file only adds a small status bundle shared by the testbench processes.
interface wsbg_tb_status_if ();
  logic stim_done;

  modport source (output stim_done);
  modport sink   (input stim_done);
endinterface

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for the Wiener spectral gain core.
// Bins go in on in_ch and come back on out_ch in order, one per item. A
// shadow noise store and shadow registers predict each output bin that is
// not typed in. Rows of a directed table run first, then random frames.
module testbench;
  import wsbg_pkg::*;

  localparam int unsigned NBINS = FFT_SIZE_DEF / 2 + 1;
  localparam int unsigned DRAIN = 200;  // idle cycles after the last expected bin is back

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [DAT_W-1:0] re;
    logic signed [DAT_W-1:0] im;
  } bin_t;

  // One directed row. has_exp: the output is typed in here, not predicted.
  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [DAT_W-1:0] re;
    logic signed [DAT_W-1:0] im;
    logic [FC_W-1:0]         fc;
    bit                      has_exp;
    logic signed [DAT_W-1:0] exp_re;
    logic signed [DAT_W-1:0] exp_im;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RED_W-1:0] cfg_wdata;

  wsbg_in_if  in_ch ();
  wsbg_out_if out_ch ();
  wsbg_tb_status_if status ();

  wiener_spectral_bin_gain_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Shadow state of the core
  logic [PWR_W-1:0] noise_est [NBINS];
  logic [RED_W-1:0] red_pct;
  bit               capture_on;

  bin_t pending_bins[$];
  int   mismatches;
  int   bins_checked;
  int   out_wait = 0;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Expected output bin for one accepted input; with capture on, updates the shadow noise store.
  function automatic bin_t wiener_bin(input logic [IDX_W-1:0] idx,
                                      input logic signed [DAT_W-1:0] re,
                                      input logic signed [DAT_W-1:0] im,
                                      input logic [FC_W-1:0] fc);
    bin_t res;
    longint signed xr, xi, r, g, nre, nim;
    longint unsigned mr, mi, pwr, old;
    res.idx = idx;
    res.re  = re;
    res.im  = im;
    if (idx < NBINS) begin
      xr = longint'(re);
      xi = longint'(im);
      mr = (xr < 0) ? -xr : xr;
      mi = (xi < 0) ? -xi : xi;
      pwr = mr * mr + mi * mi;
      if (capture_on) begin
        old = 64'(noise_est[idx]);
        noise_est[idx] = PWR_W'((longint'(fc) * old + pwr) / (longint'(fc) + 1));
      end
      g = longint'((pwr << 16) / (pwr + longint'(noise_est[idx]) + 1));
      r = (red_pct > RED_MAX) ? 100 : longint'(red_pct);
      // SV signed division truncates toward zero, same as the spec
      nre = (xr * g * r + xr * 65536 * (100 - r)) / 6553600;
      nim = (xi * g * r + xi * 65536 * (100 - r)) / 6553600;
      res.re = DAT_W'(nre);
      res.im = DAT_W'(nim);
    end
    return res;
  endfunction

  // Register write; only called while the core is idle
  task automatic write_reg(input cfg_reg_t which, input logic [RED_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == REG_REDUCTION) red_pct = val;
    else capture_on = val[0];
  endtask

  // Wait until the core has returned everything, plus a margin beyond its pipeline depth
  task automatic wait_idle();
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Present one item after a random gap, hold until accepted
  task automatic send_bin(input logic [IDX_W-1:0] idx,
                          input logic signed [DAT_W-1:0] re,
                          input logic signed [DAT_W-1:0] im,
                          input logic [FC_W-1:0] fc,
                          input bit has_exp,
                          input logic signed [DAT_W-1:0] exp_re,
                          input logic signed [DAT_W-1:0] exp_im);
    bin_t e;
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;  // bursts with no gaps
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.bin_index   <= idx;
    in_ch.bin_real    <= re;
    in_ch.bin_imag    <= im;
    in_ch.frame_count <= fc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    e = wiener_bin(idx, re, im, fc);
    if (has_exp) begin
      e.re = exp_re;
      e.im = exp_im;
    end
    pending_bins.push_back(e);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random bin at the index given by the caller, wide spread of magnitudes
  task automatic send_random(input logic [FC_W-1:0] fc, input logic [IDX_W-1:0] idx);
    logic signed [DAT_W-1:0] re, im;
    int shift;
    shift = $urandom_range(0, 23);
    re = $signed(DAT_W'($urandom())) >>> shift;
    im = $signed(DAT_W'($urandom())) >>> $urandom_range(0, 23);
    if ($urandom_range(0, 15) == 0) re = DAT_W'($urandom());
    send_bin(idx, re, im, fc, 1'b0, '0, '0);
  endtask

  // Output side: random back-pressure drawn per item, check against the oldest
  // expectation
  always @(posedge clk) begin
    bin_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: output bin %0d with nothing expected", out_ch.out_index);
      end else begin
        e = pending_bins.pop_front();
        bins_checked++;
        if (out_ch.out_index !== e.idx || out_ch.out_real !== e.re ||
            out_ch.out_imag !== e.im) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: bin exp idx=%0d re=%0d im=%0d got idx=%0d re=%0d im=%0d",
                     e.idx, e.re, e.im, out_ch.out_index, out_ch.out_real,
                     out_ch.out_imag);
        end
      end
      out_wait = $urandom_range(0, 3);
    end else if (out_wait > 0) begin
      out_wait--;
    end
    out_ch.ready <= (out_wait == 0);
  end

  // Directed rows. Reduction 0 leaves every valid bin unchanged, and
  // out-of-range bins always pass, so those outputs are typed in.
  row_t rows[] = '{
    '{10'd0,   24'sh7FFFFF, 24'sh7FFFFF, 16'd0,     1'b1, 24'sh7FFFFF, 24'sh7FFFFF},
    '{10'd512, -24'sd8388608, -24'sd8388608, 16'hFFFF, 1'b1, -24'sd8388608, -24'sd8388608},
    '{10'd513, 24'sd1234, -24'sd5, 16'd3,      1'b1, 24'sd1234, -24'sd5},
    '{10'h3FF, -24'sd1, 24'sd1, 16'd0,         1'b1, -24'sd1, 24'sd1},
    '{10'd7,   24'sd0, 24'sd0, 16'd0,          1'b1, 24'sd0, 24'sd0}
  };

  // Rows run with full reduction and capture on
  row_t rows_b[] = '{
    '{10'd0,   24'sd0, 24'sd0, 16'd0,            1'b1, 24'sd0, 24'sd0},
    '{10'd1,   24'sh7FFFFF, -24'sd8388608, 16'd0, 1'b0, '0, '0},
    '{10'd1,   24'sd100, 24'sd100, 16'hFFFF,     1'b0, '0, '0},
    '{10'd2,   24'sd1, 24'sd0, 16'd1,            1'b0, '0, '0},
    '{10'd2,   -24'sd8388608, 24'sh7FFFFF, 16'd1, 1'b0, '0, '0},
    '{10'd512, 24'sd4096, -24'sd4096, 16'd0,     1'b0, '0, '0},
    '{10'd700, 24'sh7FFFFF, 24'sh7FFFFF, 16'd9,  1'b1, 24'sh7FFFFF, 24'sh7FFFFF},
    '{10'd3,   -24'sd3, 24'sd7, 16'd0,           1'b0, '0, '0}
  };

  initial begin
    logic [RED_W-1:0] red_set [6] = '{7'd100, 7'd127, 7'd50, 7'd1, 7'd99, 7'd0};
    int frames;
    int random_sent;
    in_ch.valid = 1'b0;
    in_ch.bin_index = '0;
    in_ch.bin_real = '0;
    in_ch.bin_imag = '0;
    in_ch.frame_count = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_REDUCTION;
    cfg_wdata = '0;
    rst_n = 1'b0;
    mismatches = 0;
    bins_checked = 0;
    status.stim_done = 1'b0;
    red_pct = '0;
    capture_on = 1'b0;
    foreach (noise_est[i]) noise_est[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // After reset: reduction 0, so every bin comes back as it went in
    foreach (rows[i])
      send_bin(rows[i].idx, rows[i].re, rows[i].im, rows[i].fc,
               rows[i].has_exp, rows[i].exp_re, rows[i].exp_im);
    end_burst();
    wait_idle();

    // Full reduction with capture on, then capture off; the first row of
    // the group is zero power on an empty noise entry: gain zero.
    write_reg(REG_REDUCTION, 7'd100);
    write_reg(REG_CAPTURE, 7'd1);
    foreach (rows_b[i])
      send_bin(rows_b[i].idx, rows_b[i].re, rows_b[i].im, rows_b[i].fc,
               rows_b[i].has_exp, rows_b[i].exp_re, rows_b[i].exp_im);
    end_burst();
    wait_idle();
    write_reg(REG_CAPTURE, 7'd0);
    write_reg(REG_REDUCTION, 7'd127);  // saturates to a full reduction
    for (int i = 0; i < 4; i++)
      send_random(16'd0, IDX_W'(i));
    end_burst();
    wait_idle();

    // Random part: frames of mostly consecutive bins. Every fourth frame sets
    // reduction and capture anew; capture frames average noise. Frames stay
    // short so the run stays quick; a few bins go past the top of the store.
    random_sent = 0;
    frames = 0;
    while (random_sent < 500) begin
      int base, len;
      logic [FC_W-1:0] fc;
      if (frames % 4 == 0) begin
        write_reg(REG_REDUCTION, red_set[(frames / 4) % 6]);
        write_reg(REG_CAPTURE, RED_W'($urandom_range(0, 2) != 0));
      end
      base = $urandom_range(0, 3) == 0 ? 480 : $urandom_range(0, 40);
      len  = $urandom_range(8, 40);
      fc   = ($urandom_range(0, 7) == 0) ? FC_W'($urandom()) : FC_W'(frames);
      for (int k = 0; k < len; k++) begin
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(base + k);
        if ($urandom_range(0, 19) == 0) idx = IDX_W'($urandom());
        send_random(fc, idx);
        random_sent++;
      end
      frames++;
      // hold off now and then until everything is back
      if (frames % 4 == 0 || frames == 3) begin
        end_burst();
        wait_idle();
      end
    end
    end_burst();
    status.stim_done = 1'b1;
  end

  initial begin
    int waited;
    wait (status.stim_done);
    waited = 0;
    while (pending_bins.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN) @(posedge clk);
    $display("Checked %0d bins over directed rows and random frames,", bins_checked);
    $display("reduction 0..127 and capture on/off; %0d mismatches.", mismatches);
    if (mismatches == 0 && pending_bins.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Generous limit: ~600 items plus the reset clear
  initial begin
    #4000000;
    $display("ERROR: timeout");
    $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/wsbg_pkg.sv
sv/wsbg_if.sv
sv/wsbg_ram.sv
sv/wsbg_avg_cell.sv
sv/wsbg_gain_cell.sv
sv/wsbg_blend.sv
sv/wiener_spectral_bin_gain_core.sv
verif/wsbg_tb_if.sv
verif/testbench.sv
